/* rtl/blm_pkg.sv */
`timescale 1ns / 1ps

package blm_pkg;

  localparam int LEVELS_DEF   = 7;

  localparam int SAMPLE_W     = 12;
  localparam int SCALE_W      = 10;
  localparam int VOLT_W       = 10;
  localparam int STEP_W       = 8;
  localparam int HYST_W       = 6;

  // raw sample * scale, then drop the converter's 12 fraction bits
  localparam int SCALE_SHIFT  = 12;
  localparam int PROD_W       = SAMPLE_W + SCALE_W;
  // 1/8 exponential filter: (new + 7 * old) >> 3
  localparam int FILT_SHIFT   = 3;
  localparam int FILT_KEEP    = (1 << FILT_SHIFT) - 1;
  localparam int FILT_W       = VOLT_W + FILT_SHIFT;

  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(600);
  localparam logic [VOLT_W-1:0]  FIRST_RST = VOLT_W'(350);
  localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(10);
  localparam logic [HYST_W-1:0]  HYST_RST  = HYST_W'(5);

  typedef enum logic [1:0] {
    REG_ADC_SCALE      = 2'd0,
    REG_FIRST_BOUNDARY = 2'd1,
    REG_BOUNDARY_STEP  = 2'd2,
    REG_HYSTERESIS     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SCALE_W-1:0] adc_scale;
    logic [VOLT_W-1:0]  first_boundary;
    logic [STEP_W-1:0]  boundary_step;
    logic [HYST_W-1:0]  hysteresis;
  } blm_cfg_t;

endpackage

/* rtl/blm_regs.sv */
`timescale 1ns / 1ps

module blm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blm_pkg::PADDR_W-1:0]   paddr,
  input  logic [blm_pkg::PDATA_W-1:0]   pwdata,
  output logic [blm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output blm_pkg::blm_cfg_t             cfg
);
  import blm_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adc_scale      <= SCALE_RST;
      cfg.first_boundary <= FIRST_RST;
      cfg.boundary_step  <= STEP_RST;
      cfg.hysteresis     <= HYST_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ADC_SCALE:      cfg.adc_scale      <= pwdata[SCALE_W-1:0];
        REG_FIRST_BOUNDARY: cfg.first_boundary <= pwdata[VOLT_W-1:0];
        REG_BOUNDARY_STEP:  cfg.boundary_step  <= pwdata[STEP_W-1:0];
        REG_HYSTERESIS:     cfg.hysteresis     <= pwdata[HYST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ADC_SCALE:      prdata = PDATA_W'(cfg.adc_scale);
      REG_FIRST_BOUNDARY: prdata = PDATA_W'(cfg.first_boundary);
      REG_BOUNDARY_STEP:  prdata = PDATA_W'(cfg.boundary_step);
      REG_HYSTERESIS:     prdata = PDATA_W'(cfg.hysteresis);
      default:            prdata = '0;
    endcase
  end

endmodule

/* rtl/blm_level.sv */
`timescale 1ns / 1ps

module blm_level #(
  parameter int LEVELS = blm_pkg::LEVELS_DEF,
  parameter int LVL_W  = $clog2(LEVELS)
) (
  input  blm_pkg::blm_cfg_t                  cfg,
  input  logic [blm_pkg::SAMPLE_W-1:0]       adc_sample,
  input  logic [blm_pkg::VOLT_W-1:0]         volt_old,
  input  logic [LVL_W-1:0]                   lvl_old,
  output logic [blm_pkg::VOLT_W-1:0]         volt_new,
  output logic [LVL_W-1:0]                   lvl_new
);
  import blm_pkg::*;

  localparam int BND_W = LVL_W + STEP_W + VOLT_W + 2;
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LEVELS - 1);
  localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);

  logic [PROD_W-1:0] prod;
  logic [VOLT_W-1:0] scaled;
  logic [FILT_W-1:0] filt_sum;
  logic [BND_W-1:0]  upper;
  logic [BND_W-1:0]  lower;
  logic [BND_W-1:0]  volt_x;
  logic [BND_W-1:0]  hyst_x;
  logic              go_down;
  logic              go_up;

  assign prod     = PROD_W'(adc_sample) * PROD_W'(cfg.adc_scale);
  assign scaled   = prod[PROD_W-1:SCALE_SHIFT];
  assign filt_sum = FILT_W'(scaled) + FILT_W'(volt_old) * FILT_W'(FILT_KEEP);
  assign volt_new = filt_sum[FILT_W-1:FILT_SHIFT];

  // boundary above the current level, and the one below it
  assign upper  = BND_W'(cfg.first_boundary)
                + BND_W'(lvl_old) * BND_W'(cfg.boundary_step);
  assign lower  = upper - BND_W'(cfg.boundary_step);
  assign volt_x = BND_W'(volt_new);
  assign hyst_x = BND_W'(cfg.hysteresis);

  assign go_down = (lvl_old != '0) && (volt_x + hyst_x < lower);
  assign go_up   = (lvl_old < LVL_MAX) && (volt_x > upper + hyst_x);

  always_comb begin
    if (go_down)    lvl_new = lvl_old - LVL_ONE;
    else if (go_up) lvl_new = lvl_old + LVL_ONE;
    else            lvl_new = lvl_old;
  end

endmodule

/* rtl/battery_level_monitor_top.sv */
`timescale 1ns / 1ps

// Battery level monitor. Each input beat carries a raw 12-bit converter
// sample and the two active-low charger pins; each produces exactly one
// output beat with the filtered voltage (10 mV units), the charge level
// (0 to LEVELS-1, one step per sample at most, with hysteresis around
// first_boundary + k * boundary_step) and the charging and full flags.
// Throughput is one beat per clock while out_stall is low; there is an input
// register and a result register, and the filter and level update are
// combinational between them. The input side keeps taking beats while
// a result waits on out_stall until both registers are full. Settings on
// the APB port (adc_scale at 0x0, first_boundary 0x4, boundary_step 0x8,
// hysteresis 0xC) should only be changed while no beat is in flight.
module battery_level_monitor_top #(
  parameter int LEVELS = blm_pkg::LEVELS_DEF,
  parameter int LVL_W  = $clog2(LEVELS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blm_pkg::PADDR_W-1:0]   paddr,
  input  logic [blm_pkg::PDATA_W-1:0]   pwdata,
  output logic [blm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [blm_pkg::SAMPLE_W-1:0]  adc_sample,
  input  logic                          charge_pin,
  input  logic                          full_pin,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [blm_pkg::VOLT_W-1:0]    voltage,
  output logic [LVL_W-1:0]              level,
  output logic                          charging,
  output logic                          full_res
);
  import blm_pkg::*;

  blm_cfg_t          cfg;

  logic                in_full;
  logic [SAMPLE_W-1:0] sample_q;
  logic                chg_q;
  logic                ful_q;

  logic [VOLT_W-1:0]   filtered_voltage;
  logic [LVL_W-1:0]    charge_level;
  logic [VOLT_W-1:0]   volt_next;
  logic [LVL_W-1:0]    lvl_next;

  logic                advance;
  logic                in_take;

  blm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  blm_level #(
    .LEVELS (LEVELS),
    .LVL_W  (LVL_W)
  ) u_level (
    .cfg        (cfg),
    .adc_sample (sample_q),
    .volt_old   (filtered_voltage),
    .lvl_old    (charge_level),
    .volt_new   (volt_next),
    .lvl_new    (lvl_next)
  );

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full          <= 1'b0;
      out_valid        <= 1'b0;
      filtered_voltage <= '0;
      charge_level     <= '0;
    end else begin
      if (in_take)      in_full <= 1'b1;
      else if (advance) in_full <= 1'b0;

      if (advance)         out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      if (advance) begin
        filtered_voltage <= volt_next;
        charge_level     <= lvl_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_q <= adc_sample;
      chg_q    <= charge_pin;
      ful_q    <= full_pin;
    end
    if (advance) begin
      voltage  <= volt_next;
      level    <= lvl_next;
      charging <= !chg_q;
      full_res <= !ful_q;
    end
  end

endmodule
